>>> src/rmc_pkg.sv
package rmc_pkg;

    // Fixed field widths of the two channels
    localparam int DATA_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int PRED_W  = 2;
    localparam int COUNT_W = 7;

    // Defaults for the top-level parameters
    localparam int RULE_COUNT_DEF    = 64;
    localparam int FEATURE_COUNT_DEF = 32;

    // Command codes
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Result kind codes
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_CLASS = 1'b1;

    // Prediction codes
    localparam logic [PRED_W-1:0] PRED_LABEL0 = 2'd0;
    localparam logic [PRED_W-1:0] PRED_LABEL1 = 2'd1;
    localparam logic [PRED_W-1:0] PRED_NONE   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE,
        ST_DONE
    } state_t;

endpackage

>>> src/rmc_ram.sv
module rmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/rule_match_classifier_core.sv
// Rule-match classifier. A transaction with s_cmd = write stores one rule (valid bit, care
// mask, required values, label) into slot s_rule_slot and is answered by an acknowledge
// (m_kind = 0, all other result fields zero); a slot at or above RULE_COUNT is acknowledged
// but changes nothing. A transaction with s_cmd = classify matches the instance against every
// valid rule, drops applicable rules whose care mask is a strict subset of another applicable
// rule's mask, and predicts the shared label of the survivors or abstains (code 2). Feature
// bits at or above FEATURE_COUNT are ignored. A write goes from acceptance straight to the
// final state and from there into the result register. A classify first reads the rule
// RAM, one entry per cycle, in each of two passes: a scan pass that tests applicability
// and loads each rule's care mask into a row of compare cells, and a prune pass that
// broadcasts each applicable rule's mask to all cells at once. s_ready is high only while
// the block is idle; one result register sits on the output, and the block waits in its
// final state until that register is free.
module rule_match_classifier_core #(
    parameter int RULE_COUNT    = rmc_pkg::RULE_COUNT_DEF,
    parameter int FEATURE_COUNT = rmc_pkg::FEATURE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [rmc_pkg::SLOT_W-1:0]    s_rule_slot,
    input  logic                          s_rule_valid,
    input  logic [rmc_pkg::DATA_W-1:0]    s_rule_care,
    input  logic [rmc_pkg::DATA_W-1:0]    s_rule_required,
    input  logic                          s_rule_label,
    input  logic [rmc_pkg::DATA_W-1:0]    s_inst_assigned,
    input  logic [rmc_pkg::DATA_W-1:0]    s_inst_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [rmc_pkg::PRED_W-1:0]    m_prediction,
    output logic [rmc_pkg::COUNT_W-1:0]   m_applicable_count,
    output logic [rmc_pkg::COUNT_W-1:0]   m_maximal_count
);

    // Only the low 32 feature bits can ever arrive on the ports
    localparam int FW     = (FEATURE_COUNT < rmc_pkg::DATA_W) ? FEATURE_COUNT
                                                              : rmc_pkg::DATA_W;
    localparam int IDX_W  = $clog2(RULE_COUNT);
    localparam int CNT_W  = $clog2(RULE_COUNT + 1);
    localparam int WORD_W = 2 * FW + 1;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    rmc_pkg::state_t        state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;        // next RAM address to issue
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;  // index of data on the RAM port
    logic [RULE_COUNT-1:0]  valid_reg, valid_next;    // entry valid bits
    logic [RULE_COUNT-1:0]  app_reg, app_next;        // applicable flags from the scan
    logic [FW-1:0]          cell_care_reg [RULE_COUNT];
    logic [FW-1:0]          cell_care_next [RULE_COUNT];
    logic [FW-1:0]          asg_reg, asg_next;
    logic [FW-1:0]          val_reg, val_next;
    logic [CNT_W-1:0]       n_app_reg, n_app_next;
    logic [CNT_W-1:0]       n_max_reg, n_max_next;
    logic                   seen_reg, seen_next;
    logic                   label_reg, label_next;
    logic                   mixed_reg, mixed_next;
    logic                   kind_reg, kind_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_kind_reg, m_kind_next;
    logic [rmc_pkg::PRED_W-1:0]    m_pred_reg, m_pred_next;
    logic [rmc_pkg::COUNT_W-1:0]   m_app_reg, m_app_next;
    logic [rmc_pkg::COUNT_W-1:0]   m_max_reg, m_max_next;

    // ------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_free;
    logic pass_issue;   // issue a RAM read this cycle
    logic pass_proc;    // RAM data for rd_idx_reg is valid this cycle
    logic pass_last;    // last entry of the pass is being processed
    logic load_out;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        s_ready    = 1'b0;
        pass_issue = 1'b0;
        pass_proc  = 1'b0;
        pass_last  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            rmc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            rmc_pkg::ST_SCAN, rmc_pkg::ST_PRUNE: begin
                pass_issue = (int'(cnt_reg) < RULE_COUNT);
                pass_proc  = (cnt_reg != '0);
                pass_last  = (int'(cnt_reg) == RULE_COUNT);
            end
            rmc_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = (s_cmd == rmc_pkg::CMD_CLASSIFY) ? rmc_pkg::ST_SCAN
                                                                  : rmc_pkg::ST_DONE;
                end
            end
            rmc_pkg::ST_SCAN: begin
                if (pass_last) begin
                    state_next = rmc_pkg::ST_PRUNE;
                end
            end
            rmc_pkg::ST_PRUNE: begin
                if (pass_last) begin
                    state_next = rmc_pkg::ST_DONE;
                end
            end
            rmc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rmc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Rule RAM: {label, required, care}
    // ------------------------------------------------------------------
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic [WORD_W-1:0] rd_word;
    logic [FW-1:0]     wr_care;

    assign wr_care = s_rule_care[FW-1:0];
    assign wr_addr = IDX_W'(s_rule_slot);
    assign wr_en   = in_fire && (s_cmd == rmc_pkg::CMD_WRITE)
                     && (int'(s_rule_slot) < RULE_COUNT);
    assign wr_word = {s_rule_label, s_rule_required[FW-1:0] & wr_care, wr_care};

    rmc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RULE_COUNT)
    ) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (pass_issue),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    logic [FW-1:0] rd_care;
    logic [FW-1:0] rd_req;
    logic          rd_label;

    assign rd_care  = rd_word[FW-1:0];
    assign rd_req   = rd_word[2*FW-1:FW];
    assign rd_label = rd_word[2*FW];

    // ------------------------------------------------------------------
    // Shared compare unit
    // ------------------------------------------------------------------
    // Scan: a rule applies when every tested feature is assigned and matches.
    logic hit;
    assign hit = valid_reg[rd_idx_reg]
                 && ((rd_care & ~asg_reg) == '0)
                 && (((rd_req ^ val_reg) & rd_care) == '0);

    // Prune: the broadcast mask is compared against every cell at once. Two applicable
    // rules agree on every feature they both test, so a strict superset of the mask
    // dominates; equal masks (and the rule itself) never do.
    logic [RULE_COUNT-1:0] dom_vec;
    logic                  dominated;

    always_comb begin
        for (int j = 0; j < RULE_COUNT; j++) begin
            dom_vec[j] = app_reg[j]
                         && ((rd_care & ~cell_care_reg[j]) == '0)
                         && (rd_care != cell_care_reg[j]);
        end
    end

    assign dominated = |dom_vec;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        valid_next  = valid_reg;
        app_next    = app_reg;
        asg_next    = asg_reg;
        val_next    = val_reg;
        n_app_next  = n_app_reg;
        n_max_next  = n_max_reg;
        seen_next   = seen_reg;
        label_next  = label_reg;
        mixed_next  = mixed_reg;
        kind_next   = kind_reg;
        for (int k = 0; k < RULE_COUNT; k++) begin
            cell_care_next[k] = cell_care_reg[k];
        end

        if (wr_en) begin
            valid_next[wr_addr] = s_rule_valid;
        end

        if (in_fire) begin
            asg_next   = s_inst_assigned[FW-1:0];
            val_next   = s_inst_value[FW-1:0];
            kind_next  = s_cmd;
            app_next   = '0;
            n_app_next = '0;
            n_max_next = '0;
            seen_next  = 1'b0;
            mixed_next = 1'b0;
            cnt_next   = '0;
        end

        if (pass_issue) begin
            rd_idx_next = cnt_reg[IDX_W-1:0];
            cnt_next    = cnt_reg + 1'b1;
        end
        if (pass_last) begin
            cnt_next = '0;
        end

        if (pass_proc && (state_reg == rmc_pkg::ST_SCAN)) begin
            cell_care_next[rd_idx_reg] = rd_care;
            if (hit) begin
                app_next[rd_idx_reg] = 1'b1;
                n_app_next           = n_app_reg + 1'b1;
            end
        end

        if (pass_proc && (state_reg == rmc_pkg::ST_PRUNE)) begin
            if (app_reg[rd_idx_reg] && !dominated) begin
                n_max_next = n_max_reg + 1'b1;
                if (!seen_reg) begin
                    seen_next  = 1'b1;
                    label_next = rd_label;
                end else if (label_reg != rd_label) begin
                    mixed_next = 1'b1;
                end
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_pred_next  = m_pred_reg;
        m_app_next   = m_app_reg;
        m_max_next   = m_max_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_kind_next  = kind_reg;
            m_app_next   = rmc_pkg::COUNT_W'(n_app_reg);
            m_max_next   = rmc_pkg::COUNT_W'(n_max_reg);
            if (kind_reg == rmc_pkg::KIND_ACK) begin
                m_pred_next = rmc_pkg::PRED_LABEL0;
            end else if (seen_reg && !mixed_reg) begin
                m_pred_next = rmc_pkg::PRED_W'(label_reg);
            end else begin
                m_pred_next = rmc_pkg::PRED_NONE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rmc_pkg::ST_IDLE;
            cnt_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        app_reg    <= app_next;
        asg_reg    <= asg_next;
        val_reg    <= val_next;
        n_app_reg  <= n_app_next;
        n_max_reg  <= n_max_next;
        seen_reg   <= seen_next;
        label_reg  <= label_next;
        mixed_reg  <= mixed_next;
        kind_reg   <= kind_next;
        m_kind_reg <= m_kind_next;
        m_pred_reg <= m_pred_next;
        m_app_reg  <= m_app_next;
        m_max_reg  <= m_max_next;
        for (int k = 0; k < RULE_COUNT; k++) begin
            cell_care_reg[k] <= cell_care_next[k];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_kind             = m_kind_reg;
    assign m_prediction       = m_pred_reg;
    assign m_applicable_count = m_app_reg;
    assign m_maximal_count    = m_max_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Survivors of the prune pass are a subset of the applicable rules.
    a_max_le_app: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_max_reg <= m_app_reg))
        else $error("maximal count exceeds applicable count");

    // A nonempty set of applicable rules always keeps at least one maximal rule.
    a_max_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == rmc_pkg::KIND_CLASS) && (m_app_reg != '0))
        |-> (m_max_reg != '0))
        else $error("applicable rules but no maximal rule");

    // No applicable rule means abstain.
    a_empty_abstain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == rmc_pkg::KIND_CLASS) && (m_app_reg == '0))
        |-> (m_pred_reg == rmc_pkg::PRED_NONE))
        else $error("no applicable rule but a label was predicted");

    // Write acknowledges carry all-zero result fields.
    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == rmc_pkg::KIND_ACK))
        |-> ((m_pred_reg == rmc_pkg::PRED_LABEL0) && (m_app_reg == '0) && (m_max_reg == '0)))
        else $error("write acknowledge with nonzero result fields");

    // The prune pass never counts more survivors than the scan found.
    a_prune_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmc_pkg::ST_PRUNE) |-> (n_max_reg <= n_app_reg))
        else $error("prune count ran past the applicable count");

endmodule

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Block size under test: package defaults
    localparam int RULES = rmc_pkg::RULE_COUNT_DEF;
    localparam int FEATS = rmc_pkg::FEATURE_COUNT_DEF;
    localparam logic [rmc_pkg::DATA_W-1:0] FEAT_MASK =
        (FEATS >= rmc_pkg::DATA_W) ? '1 : ((32'd1 << FEATS) - 32'd1);

    localparam int WATCHDOG_LIMIT = 4000;  // covers a classify plus receiver stalls
    localparam int TAIL_CYCLES    = 2 * (RULES + 1) + 10;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic                         cmd;
        logic [rmc_pkg::SLOT_W-1:0]   slot;
        logic                         rule_on;
        logic [rmc_pkg::DATA_W-1:0]   care;
        logic [rmc_pkg::DATA_W-1:0]   required;
        logic                         label;
        logic [rmc_pkg::DATA_W-1:0]   assigned;
        logic [rmc_pkg::DATA_W-1:0]   inst_val;
    } rmc_item_t;

    typedef struct packed {
        logic                         kind;
        logic [rmc_pkg::PRED_W-1:0]   prediction;
        logic [rmc_pkg::COUNT_W-1:0]  applicable;
        logic [rmc_pkg::COUNT_W-1:0]  maximal;
    } rmc_verdict_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic                         s_cmd           = rmc_pkg::CMD_WRITE;
    logic [rmc_pkg::SLOT_W-1:0]   s_rule_slot     = '0;
    logic                         s_rule_valid    = 1'b0;
    logic [rmc_pkg::DATA_W-1:0]   s_rule_care     = '0;
    logic [rmc_pkg::DATA_W-1:0]   s_rule_required = '0;
    logic                         s_rule_label    = 1'b0;
    logic [rmc_pkg::DATA_W-1:0]   s_inst_assigned = '0;
    logic [rmc_pkg::DATA_W-1:0]   s_inst_value    = '0;

    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic                         m_kind;
    logic [rmc_pkg::PRED_W-1:0]   m_prediction;
    logic [rmc_pkg::COUNT_W-1:0]  m_applicable_count;
    logic [rmc_pkg::COUNT_W-1:0]  m_maximal_count;

    initial begin
        forever #5 aclk = ~aclk;
    end

    rule_match_classifier_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_rule_slot        (s_rule_slot),
        .s_rule_valid       (s_rule_valid),
        .s_rule_care        (s_rule_care),
        .s_rule_required    (s_rule_required),
        .s_rule_label       (s_rule_label),
        .s_inst_assigned    (s_inst_assigned),
        .s_inst_value       (s_inst_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_prediction       (m_prediction),
        .m_applicable_count (m_applicable_count),
        .m_maximal_count    (m_maximal_count)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the rule table, updated as each request is accepted
    // ------------------------------------------------------------------
    bit                         tbl_on    [RULES];
    logic [rmc_pkg::DATA_W-1:0] tbl_care  [RULES];
    logic [rmc_pkg::DATA_W-1:0] tbl_req   [RULES];
    logic                       tbl_label [RULES];

    rmc_item_t    queued_requests[$];   // waiting for the driver
    rmc_verdict_t expected_verdicts[$]; // accepted, answer not yet seen
    rmc_item_t    drive_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int requests_sent  = 0;
    int classify_seen  = 0;
    int decided_seen   = 0;  // classifications that did not abstain
    int peak_applicable = 0;
    int peak_maximal    = 0;
    int stall_cycles    = 0;

    // Random stimulus shaping: rules mostly test a few features in a
    // narrow window and require the values of a common world vector, so
    // instances built from that vector match many rules with nested masks.
    logic [rmc_pkg::DATA_W-1:0] world_bits = '0;
    logic [rmc_pkg::DATA_W-1:0] pool_mask  = 32'h0000_03FF;
    logic                       favored_label = 1'b0;

    // Writes store a rule; classifies match, prune dominated rules, vote.
    function automatic rmc_verdict_t apply_to_rule_table(rmc_item_t it);
        rmc_verdict_t               res;
        bit                         hit [RULES];
        logic [rmc_pkg::DATA_W-1:0] asg, val, ci, cj, care;
        int                         n_hit, n_top, label_seen;
        bit                         mixed, dominated;

        res = '0;
        if (it.cmd == rmc_pkg::CMD_WRITE) begin
            if (int'(it.slot) < RULES) begin
                care                = it.care & FEAT_MASK;
                tbl_on[it.slot]     = it.rule_on;
                tbl_care[it.slot]   = care;
                tbl_req[it.slot]    = it.required & care;
                tbl_label[it.slot]  = it.label;
            end
            res.kind = rmc_pkg::KIND_ACK;
            return res;
        end

        asg   = it.assigned & FEAT_MASK;
        val   = it.inst_val & FEAT_MASK;
        n_hit = 0;
        for (int i = 0; i < RULES; i++) begin
            hit[i] = tbl_on[i] && ((tbl_care[i] & ~asg) == '0)
                     && (((tbl_req[i] ^ val) & tbl_care[i]) == '0);
            if (hit[i]) n_hit++;
        end

        // Drop rules whose mask is a strict subset of another hit's mask
        n_top      = 0;
        label_seen = -1;
        mixed      = 1'b0;
        for (int i = 0; i < RULES; i++) begin
            if (hit[i]) begin
                dominated = 1'b0;
                ci = tbl_care[i];
                for (int j = 0; j < RULES; j++) begin
                    cj = tbl_care[j];
                    if (j != i && hit[j] && ((ci & ~cj) == '0) && ci != cj
                        && (((tbl_req[i] ^ tbl_req[j]) & ci) == '0))
                        dominated = 1'b1;
                end
                if (!dominated) begin
                    n_top++;
                    if (label_seen < 0)
                        label_seen = int'(tbl_label[i]);
                    else if (label_seen != int'(tbl_label[i]))
                        mixed = 1'b1;
                end
            end
        end

        res.kind       = rmc_pkg::KIND_CLASS;
        res.applicable = rmc_pkg::COUNT_W'(n_hit);
        res.maximal    = rmc_pkg::COUNT_W'(n_top);
        if (label_seen < 0 || mixed)
            res.prediction = rmc_pkg::PRED_NONE;
        else
            res.prediction = (label_seen == 1) ? rmc_pkg::PRED_LABEL1 : rmc_pkg::PRED_LABEL0;
        return res;
    endfunction

    function automatic rmc_item_t random_request();
        rmc_item_t it;
        int        pick;

        it.cmd      = 1'($urandom_range(0, 1));
        it.slot     = rmc_pkg::SLOT_W'($urandom_range(0, RULES - 1));
        it.rule_on  = 1'($urandom_range(0, 1));
        it.care     = $urandom;
        it.required = $urandom;
        it.label    = 1'($urandom_range(0, 1));
        it.assigned = $urandom;
        it.inst_val = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return it;  // pure noise
        if (pick < 50) begin
            it.cmd     = rmc_pkg::CMD_WRITE;
            it.rule_on = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) != 0)
                it.care = $urandom & $urandom & pool_mask;
            if ($urandom_range(0, 6) != 0)
                it.required = world_bits;  // bits outside care left set on purpose
            it.label = ($urandom_range(0, 3) != 0) ? favored_label : ~favored_label;
        end else begin
            it.cmd = rmc_pkg::CMD_CLASSIFY;
            if ($urandom_range(0, 4) != 0)
                it.assigned = it.assigned | pool_mask;
            it.inst_val = world_bits;
            if ($urandom_range(0, 2) == 0)
                it.inst_val[$urandom_range(0, rmc_pkg::DATA_W - 1)] ^= 1'b1;
        end
        return it;
    endfunction

    task automatic queue_write(input int slot, input logic on,
                               input logic [rmc_pkg::DATA_W-1:0] care, req,
                               input logic lbl);
        rmc_item_t it;
        it          = '0;
        it.cmd      = rmc_pkg::CMD_WRITE;
        it.slot     = rmc_pkg::SLOT_W'(slot);
        it.rule_on  = on;
        it.care     = care;
        it.required = req;
        it.label    = lbl;
        it.assigned = $urandom;  // ignored by a write
        it.inst_val = $urandom;
        queued_requests.push_back(it);
    endtask

    task automatic queue_classify(input logic [rmc_pkg::DATA_W-1:0] asg, val);
        rmc_item_t it;
        it          = '0;
        it.cmd      = rmc_pkg::CMD_CLASSIFY;
        it.slot     = rmc_pkg::SLOT_W'($urandom);  // rule fields ignored by a classify
        it.care     = $urandom;
        it.assigned = asg;
        it.inst_val = val;
        queued_requests.push_back(it);
    endtask

    // Sender holds off until every accepted transaction has been answered
    task automatic drain();
        while (queued_requests.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input rmc_verdict_t want,
                                 input rmc_verdict_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"[%0t] %s: expected kind=%0d pred=%0d app=%0d max=%0d,",
                      " got kind=%0d pred=%0d app=%0d max=%0d"},
                     $realtime, what, want.kind, want.prediction, want.applicable,
                     want.maximal, got.kind, got.prediction, got.applicable, got.maximal);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued requests, predicts each one on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_verdicts.push_back(apply_to_rule_table(drive_item));
                requests_sent++;
            end
            // Load a new transaction only when the slot is empty or just taken
            if (!s_valid || s_ready) begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    drive_item       = queued_requests.pop_front();
                    s_valid         <= 1'b1;
                    s_cmd           <= drive_item.cmd;
                    s_rule_slot     <= drive_item.slot;
                    s_rule_valid    <= drive_item.rule_on;
                    s_rule_care     <= drive_item.care;
                    s_rule_required <= drive_item.required;
                    s_rule_label    <= drive_item.label;
                    s_inst_assigned <= drive_item.assigned;
                    s_inst_value    <= drive_item.inst_val;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rmc_verdict_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_prediction, m_applicable_count, m_maximal_count};
                if (expected_verdicts.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.kind !== want.kind || got.prediction !== want.prediction
                        || got.applicable !== want.applicable || got.maximal !== want.maximal)
                        note_mismatch("result mismatch", want, got);
                    if (want.kind == rmc_pkg::KIND_CLASS) begin
                        classify_seen++;
                        if (want.prediction != rmc_pkg::PRED_NONE) decided_seen++;
                        if (int'(want.applicable) > peak_applicable)
                            peak_applicable = int'(want.applicable);
                        if (int'(want.maximal) > peak_maximal)
                            peak_maximal = int'(want.maximal);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, then four random phases
    // ------------------------------------------------------------------
    initial begin
        int send_pct [4];
        int recv_pct [4];

        send_pct = '{0, 75, 0, 17};
        recv_pct = '{0, 0, 75, 17};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty table: abstain with zero counts, for extreme instances
        queue_classify('0, '1);
        queue_classify('1, '0);
        // Empty rule always applies
        queue_write(0, 1'b1, '0, '1, 1'b1);
        queue_classify('0, '0);
        // Full-mask rule in the top slot dominates the empty rule
        queue_write(RULES - 1, 1'b1, '1, '1, 1'b0);
        queue_classify('1, '1);
        queue_classify('1, '0);
        // Equal care masks with opposing labels: neither dominates -> abstain;
        // required bits outside the mask must be dropped on the first write
        queue_write(1, 1'b1, 32'h0000_00F0, 32'hFFFF_FF30, 1'b1);
        queue_write(2, 1'b1, 32'h0000_00F0, 32'h0000_0030, 1'b0);
        queue_classify(32'h0000_00FF, 32'h0000_0030);
        // Invalidate one of the pair
        queue_write(2, 1'b0, 32'h0000_00F0, 32'h0000_0030, 1'b0);
        queue_classify(32'h0000_00FF, 32'h0000_0030);
        // Tested feature left unassigned
        queue_classify(32'h0000_007F, 32'h0000_0030);
        // Edge features, incomparable masks with different labels
        queue_write(5, 1'b1, 32'h8000_0001, 32'h8000_0000, 1'b0);
        queue_classify(32'h8000_00F1, 32'h8000_0030);
        // Rewrite the top slot: full mask requiring all zeros
        queue_write(RULES - 1, 1'b1, '1, '0, 1'b1);
        queue_classify('1, '0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            world_bits     = $urandom;
            pool_mask      = 32'h0000_03FF << $urandom_range(0, rmc_pkg::DATA_W - 10);
            favored_label  = 1'($urandom_range(0, 1));
            for (int n = 0; n < 160; n++)
                queued_requests.push_back(random_request());
            // Pause between phases until every answer is back
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += expected_verdicts.size();

        $display("covered %0d transactions, %0d classifications (%0d decided, rest abstained)",
                 requests_sent, classify_seen, decided_seen);
        $display("largest applicable set %0d, largest surviving set %0d, %0d mismatches",
                 peak_applicable, peak_maximal, mismatches);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
